>>> hw/rtl/kmi_pkg.sv
package kmi_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_POINT = 1'b1;

  localparam logic KIND_ASSIGN   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  localparam int unsigned KW        = 7;   // holds k up to 127 clusters
  localparam int unsigned DIST_LAT  = 3;   // distance unit register stages
  localparam logic [4:0]  K_RESET   = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_MEAN_HEAD,
    ST_MEAN_DIV
  } kmi_state_e;

  typedef struct packed {
    logic              command;
    logic [3:0]        centroid_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic              last_point;
  } kmi_in_t;

  typedef struct packed {
    logic              result_kind;
    logic [3:0]        cluster_index;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic              last_result;
  } kmi_out_t;

endpackage

>>> hw/rtl/kmeans_2d_iteration_core.sv
// Load item: busy stays low. Point item: one ring rotation through the distance unit
// (its three register stages), then an emit state.
// Last point then walks the ring again: each nonempty centroid in use goes through the
// restoring divider, and each empty or unused ring slot simply shifts on.
// Results are registered strobes the receiver cannot stall.
// Async active-low reset clears all centroids, sums, counts; k resets to 4.
module kmeans_2d_iteration_core
  import kmi_pkg::*;
#(
  parameter int unsigned MAX_CLUSTERS = 16,
  parameter int unsigned MAX_POINTS   = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  kmi_in_t    item_i,
  output kmi_out_t   result_o,
  output logic       result_strobe_o,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i
);

  localparam int unsigned N   = MAX_CLUSTERS;
  localparam int unsigned IW  = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned SCW = $clog2(N + DIST_LAT);
  localparam int unsigned CW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned SW  = 17 + CW;
  localparam int unsigned DW  = SW + 8;

  kmi_state_e state_q, state_d;
  logic [SCW-1:0] st_q, st_d;
  logic [4:0]     num_q;
  logic           pend_v_q, pend_v_d;
  logic [IW-1:0]  pend_idx_q, pend_idx_d;
  logic signed [15:0] pend_x_q, pend_y_q, pend_x_d, pend_y_d;
  logic signed [15:0] px_q, py_q;
  logic           last_q;
  kmi_out_t       res_q, res_d;
  logic           strobe_q, strobe_d;

  logic signed [23:0]   cx [N];
  logic signed [23:0]   cy [N];
  logic signed [SW-1:0] sx [N];
  logic signed [SW-1:0] sy [N];
  logic [CW-1:0]        cnt [N];

  logic                 shift_en;
  logic signed [23:0]   tail_cx, tail_cy;
  logic signed [SW-1:0] tail_sx, tail_sy;
  logic [CW-1:0]        tail_cnt;

  logic                 accept, add_en, in_use, is_last_k, div_start, div_done;
  logic [KW-1:0]        k_use;
  logic signed [SW-1:0] hu_sx, hu_sy;
  logic [CW-1:0]        hu_cnt;
  logic [SW-1:0]        mag_x, mag_y;
  logic [DW-1:0]        qx, qy, sqx, sqy;
  logic signed [23:0]   mx, my;
  logic [IW-1:0]        best_idx;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    if (num_q == 5'd0) begin
      k_use = KW'(1);
    end else if (KW'(num_q) > KW'(N)) begin
      k_use = KW'(N);
    end else begin
      k_use = KW'(num_q);
    end
  end

  // Ring of cells: cell 0 is the head, its updated entry re-enters at the tail.
  for (genvar j = 0; j < N; j++) begin : g_cell
    logic load_en;
    logic signed [23:0]   nx_cx, nx_cy;
    logic signed [SW-1:0] nx_sx, nx_sy;
    logic [CW-1:0]        nx_cnt;
    assign load_en = accept && (item_i.command == CMD_LOAD)
                     && (KW'(item_i.centroid_index) == KW'(j));
    if (j == N - 1) begin : g_tail
      assign nx_cx = tail_cx;   assign nx_cy = tail_cy;
      assign nx_sx = tail_sx;   assign nx_sy = tail_sy;
      assign nx_cnt = tail_cnt;
    end else begin : g_mid
      assign nx_cx = cx[j+1];   assign nx_cy = cy[j+1];
      assign nx_sx = sx[j+1];   assign nx_sy = sy[j+1];
      assign nx_cnt = cnt[j+1];
    end
    kmi_cell #(.SW(SW), .CW(CW)) u_cell (
      .clk_i, .rst_ni,
      .shift_i  (shift_en),
      .load_i   (load_en),
      .load_x_i ({item_i.coord_x, 8'h00}),
      .load_y_i ({item_i.coord_y, 8'h00}),
      .cx_i(nx_cx), .cy_i(nx_cy), .sx_i(nx_sx), .sy_i(nx_sy), .cnt_i(nx_cnt),
      .cx_o(cx[j]), .cy_o(cy[j]), .sx_o(sx[j]), .sy_o(sy[j]), .cnt_o(cnt[j])
    );
  end

  // pending point from the previous assignment folds in as its entry passes the head
  assign add_en = pend_v_q && (pend_idx_q == st_q[IW-1:0])
                  && (cnt[0] != CW'(MAX_POINTS));
  assign hu_cnt = cnt[0] + CW'(add_en);
  assign hu_sx  = sx[0] + (add_en ? {{(SW-16){pend_x_q[15]}}, pend_x_q} : '0);
  assign hu_sy  = sy[0] + (add_en ? {{(SW-16){pend_y_q[15]}}, pend_y_q} : '0);

  assign mag_x = hu_sx[SW-1] ? SW'(-hu_sx) : SW'(hu_sx);
  assign mag_y = hu_sy[SW-1] ? SW'(-hu_sy) : SW'(hu_sy);
  assign sqx   = hu_sx[SW-1] ? DW'(-qx) : qx;
  assign sqy   = hu_sy[SW-1] ? DW'(-qy) : qy;
  assign mx    = sqx[23:0];
  assign my    = sqy[23:0];

  assign in_use    = KW'(st_q) < k_use;
  assign is_last_k = (KW'(st_q) + KW'(1)) == k_use;

  kmi_dist #(.IW(IW)) u_dist (
    .clk_i, .rst_ni,
    .clear_i    (accept),
    .valid_i    ((state_q == ST_SCAN) && (st_q < SCW'(N)) && in_use),
    .idx_i      (st_q[IW-1:0]),
    .px_i       (px_q),
    .py_i       (py_q),
    .cx_i       (cx[0]),
    .cy_i       (cy[0]),
    .best_idx_o (best_idx)
  );

  kmi_div #(.DW(DW), .CW(CW)) u_div_x (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i ({mag_x, 8'h00}),
    .divisor_i  (hu_cnt),
    .done_o     (div_done),
    .quotient_o (qx)
  );

  kmi_div #(.DW(DW), .CW(CW)) u_div_y (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i ({mag_y, 8'h00}),
    .divisor_i  (hu_cnt),
    .done_o     (),
    .quotient_o (qy)
  );

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    pend_x_d   = pend_x_q;
    pend_y_d   = pend_y_q;
    res_d      = '0;
    strobe_d   = 1'b0;
    shift_en   = 1'b0;
    div_start  = 1'b0;
    tail_cx    = cx[0];
    tail_cy    = cy[0];
    tail_sx    = hu_sx;
    tail_sy    = hu_sy;
    tail_cnt   = hu_cnt;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && item_i.command == CMD_POINT) begin
          state_d = ST_SCAN;
          st_d    = '0;
        end
      end
      ST_SCAN: begin
        shift_en = st_q < SCW'(N);
        st_d     = st_q + 1'b1;
        if (st_q == SCW'(N + DIST_LAT - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_d            = 1'b1;
        res_d.result_kind   = KIND_ASSIGN;
        res_d.cluster_index = 4'(best_idx);
        res_d.last_result   = !last_q;
        pend_v_d            = 1'b1;
        pend_idx_d          = best_idx;
        pend_x_d            = px_q;
        pend_y_d            = py_q;
        st_d                = '0;
        state_d             = last_q ? ST_MEAN_HEAD : ST_IDLE;
      end
      ST_MEAN_HEAD: begin
        if (in_use && hu_cnt != '0) begin
          div_start = 1'b1;
          state_d   = ST_MEAN_DIV;
        end else begin
          shift_en = 1'b1;
          tail_sx  = '0;
          tail_sy  = '0;
          tail_cnt = '0;
          if (in_use) begin
            strobe_d            = 1'b1;
            res_d.result_kind   = KIND_CENTROID;
            res_d.cluster_index = 4'(st_q);
            res_d.mean_x        = cx[0];
            res_d.mean_y        = cy[0];
            res_d.last_result   = is_last_k;
          end
          st_d = st_q + 1'b1;
          if (st_q == SCW'(N - 1)) begin
            state_d  = ST_IDLE;
            pend_v_d = 1'b0;
          end
        end
      end
      ST_MEAN_DIV: begin
        if (div_done) begin
          shift_en            = 1'b1;
          tail_cx             = mx;
          tail_cy             = my;
          tail_sx             = '0;
          tail_sy             = '0;
          tail_cnt            = '0;
          strobe_d            = 1'b1;
          res_d.result_kind   = KIND_CENTROID;
          res_d.cluster_index = 4'(st_q);
          res_d.mean_x        = mx;
          res_d.mean_y        = my;
          res_d.last_result   = is_last_k;
          st_d                = st_q + 1'b1;
          if (st_q == SCW'(N - 1)) begin
            state_d  = ST_IDLE;
            pend_v_d = 1'b0;
          end else begin
            state_d = ST_MEAN_HEAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      st_q     <= '0;
      num_q    <= K_RESET;
      pend_v_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      st_q     <= st_d;
      pend_v_q <= pend_v_d;
      strobe_q <= strobe_d;
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    pend_x_q   <= pend_x_d;
    pend_y_q   <= pend_y_d;
    res_q      <= res_d;
    if (accept) begin
      px_q   <= item_i.coord_x;
      py_q   <= item_i.coord_y;
      last_q <= item_i.last_point;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule

>>> hw/rtl/kmi_cell.sv
module kmi_cell
  import kmi_pkg::*;
#(
  parameter int unsigned SW = 34,
  parameter int unsigned CW = 17
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic signed [23:0]   load_x_i,
  input  logic signed [23:0]   load_y_i,
  input  logic signed [23:0]   cx_i,
  input  logic signed [23:0]   cy_i,
  input  logic signed [SW-1:0] sx_i,
  input  logic signed [SW-1:0] sy_i,
  input  logic [CW-1:0]        cnt_i,
  output logic signed [23:0]   cx_o,
  output logic signed [23:0]   cy_o,
  output logic signed [SW-1:0] sx_o,
  output logic signed [SW-1:0] sy_o,
  output logic [CW-1:0]        cnt_o
);

  logic signed [23:0]   cx_q, cy_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic [CW-1:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      cnt_q <= '0;
    end else if (shift_i) begin
      cx_q  <= cx_i;
      cy_q  <= cy_i;
      sx_q  <= sx_i;
      sy_q  <= sy_i;
      cnt_q <= cnt_i;
    end else if (load_i) begin
      cx_q <= load_x_i;
      cy_q <= load_y_i;
    end
  end

  assign cx_o  = cx_q;
  assign cy_o  = cy_q;
  assign sx_o  = sx_q;
  assign sy_o  = sy_q;
  assign cnt_o = cnt_q;

endmodule

>>> hw/rtl/kmi_dist.sv
module kmi_dist
  import kmi_pkg::*;
#(
  parameter int unsigned IW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                clear_i,
  input  logic                valid_i,
  input  logic [IW-1:0]       idx_i,
  input  logic signed [15:0]  px_i,
  input  logic signed [15:0]  py_i,
  input  logic signed [23:0]  cx_i,
  input  logic signed [23:0]  cy_i,
  output logic [IW-1:0]       best_idx_o
);

  logic               v1_q, v2_q, v3_q;
  logic [IW-1:0]      i1_q, i2_q, i3_q;
  logic signed [24:0] dx_q, dy_q;
  logic [48:0]        sqx_q, sqy_q;
  logic [49:0]        d_q;
  logic signed [49:0] prodx, prody;
  logic [49:0]        best_d_q;
  logic [IW-1:0]      best_idx_q;
  logic               best_v_q;

  assign prodx = dx_q * dx_q;
  assign prody = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      best_v_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (clear_i) begin
        best_v_q <= 1'b0;
      end else if (v3_q) begin
        best_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q  <= idx_i;
    dx_q  <= {px_i[15], px_i, 8'h00} - {cx_i[23], cx_i};
    dy_q  <= {py_i[15], py_i, 8'h00} - {cy_i[23], cy_i};
    i2_q  <= i1_q;
    sqx_q <= prodx[48:0];
    sqy_q <= prody[48:0];
    i3_q  <= i2_q;
    d_q   <= {1'b0, sqx_q} + {1'b0, sqy_q};
    // strict less-than keeps the lowest index on a tie
    if (v3_q && (!best_v_q || d_q < best_d_q)) begin
      best_d_q   <= d_q;
      best_idx_q <= i3_q;
    end
  end

  assign best_idx_o = best_idx_q;

endmodule

>>> hw/rtl/kmi_div.sv
module kmi_div
  import kmi_pkg::*;
#(
  parameter int unsigned DW = 42,
  parameter int unsigned CW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned NW = $clog2(DW + 1);

  logic [CW-1:0] rem_q, dvs_q;
  logic [DW-1:0] quo_q;
  logic [NW-1:0] n_q;
  logic          run_q, done_q;
  logic [CW:0]   trial;
  logic          fits;

  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      n_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        n_q   <= '0;
      end else if (run_q) begin
        n_q <= n_q + 1'b1;
        if (n_q == NW'(DW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= fits ? CW'(trial - {1'b0, dvs_q}) : trial[CW-1:0];
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hw/rtl/kmi_checker.sv
module kmi_checker
  import kmi_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input kmi_in_t  item_i,
  input kmi_out_t result_o,
  input logic     result_strobe_o
);

  // assignments carry no coordinates
  a_assign_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.result_kind == KIND_ASSIGN
    |-> result_o.mean_x == '0 && result_o.mean_y == '0)
    else $error("assignment item with nonzero mean");

  a_point_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.command == CMD_POINT |=> busy)
    else $error("point item did not raise busy");

  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.command == CMD_LOAD |=> !busy && !result_strobe_o)
    else $error("load item caused activity");

  // no result strobe comes right after the final result of an input
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_o.last_result |=> !result_strobe_o)
    else $error("result after last_result");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result while idle");

endmodule

bind kmeans_2d_iteration_core kmi_checker u_kmi_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .item_i          (item_i),
  .result_o        (result_o),
  .result_strobe_o (result_strobe_o)
);
